@@ rtl/htfd_pkg.sv @@
package htfd_pkg;

  // CRC-8 settings of the sensor frame: polynomial x^8+x^5+x^4+1, MSB first.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions inside one six-byte frame, in bus order.
  localparam logic [2:0] POS_TEMP_MSB = 3'd0;
  localparam logic [2:0] POS_TEMP_LSB = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_MSB  = 3'd3;
  localparam logic [2:0] POS_HUM_LSB  = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  // Fixed-point scale factors applied to a 16-bit raw word (result >> 16).
  localparam int TEMP_SCALE  = 17500;
  localparam int TEMP_OFFSET = 4500;
  localparam int HUM_SCALE   = 100;

  localparam int TEMP_W = 15;
  localparam int HUM_W  = 7;

  // One decoded frame result.
  typedef struct packed {
    logic                     hum_crc_ok;
    logic                     temp_crc_ok;
    logic [HUM_W-1:0]         humidity_percent;
    logic signed [TEMP_W-1:0] temperature_centideg;
  } result_t;

endpackage

@@ rtl/htfd_crc8.sv @@
module htfd_crc8 (
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  output logic [7:0] crc_out
);

  // Eight shift steps of the CRC register after folding in the byte.
  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data_in;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ htfd_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

@@ rtl/htfd_convert.sv @@
module htfd_convert (
  input  logic [15:0]                              raw,
  output logic signed [htfd_pkg::TEMP_W-1:0]       temp_centideg,
  output logic [htfd_pkg::HUM_W-1:0]               hum_percent
);

  logic [30:0]                   temp_prod;
  logic [htfd_pkg::TEMP_W-1:0]   temp_scaled;
  logic [22:0]                   hum_prod;

  // Temperature: raw * 17500 / 65536, then the offset of 45.00 degrees.
  assign temp_prod     = 31'(raw) * 31'(htfd_pkg::TEMP_SCALE);
  assign temp_scaled   = temp_prod[30:16];
  assign temp_centideg = $signed(temp_scaled - htfd_pkg::TEMP_W'(htfd_pkg::TEMP_OFFSET));

  // Humidity: raw * 100 / 65536, truncated.
  assign hum_prod    = 23'(raw) * 23'(htfd_pkg::HUM_SCALE);
  assign hum_percent = hum_prod[22:16];

endmodule

@@ rtl/htfd_frame.sv @@
module htfd_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  output logic                has_result,
  output htfd_pkg::result_t   result
);

  logic [2:0]                            pos_r, pos_nxt, eff_pos;
  logic [7:0]                            crc_r, crc_nxt, crc_base, crc_new;
  logic [15:0]                           word_r, word_nxt;
  logic signed [htfd_pkg::TEMP_W-1:0]    held_temp_r, held_temp_nxt, conv_temp;
  logic [htfd_pkg::HUM_W-1:0]            held_hum_r, held_hum_nxt, conv_hum;
  logic                                  temp_ok_r, temp_ok_nxt;
  logic                                  crc_match;
  logic                                  restart;

  // A start mark or an impossible position restarts the frame.
  assign restart  = frame_start || (pos_r > htfd_pkg::POS_HUM_CRC);
  assign eff_pos  = restart ? htfd_pkg::POS_TEMP_MSB : pos_r;
  assign crc_base = restart ? htfd_pkg::CRC_INIT : crc_r;
  assign crc_match = (crc_base == rx_byte);

  htfd_crc8 u_crc (
    .crc_in  (crc_base),
    .data_in (rx_byte),
    .crc_out (crc_new)
  );

  htfd_convert u_conv (
    .raw           (word_r),
    .temp_centideg (conv_temp),
    .hum_percent   (conv_hum)
  );

  // Next state for one byte.
  always_comb begin
    word_nxt      = word_r;
    crc_nxt       = htfd_pkg::CRC_INIT;
    held_temp_nxt = held_temp_r;
    held_hum_nxt  = held_hum_r;
    temp_ok_nxt   = temp_ok_r;
    case (eff_pos)
      htfd_pkg::POS_TEMP_MSB, htfd_pkg::POS_HUM_MSB: begin
        word_nxt = {rx_byte, 8'h00};
        crc_nxt  = crc_new;
      end
      htfd_pkg::POS_TEMP_LSB, htfd_pkg::POS_HUM_LSB: begin
        word_nxt = {word_r[15:8], rx_byte};
        crc_nxt  = crc_new;
      end
      htfd_pkg::POS_TEMP_CRC: begin
        temp_ok_nxt = crc_match;
        if (crc_match) begin
          held_temp_nxt = conv_temp;
        end
      end
      default: begin
        if (crc_match) begin
          held_hum_nxt = conv_hum;
        end
      end
    endcase
    pos_nxt = (eff_pos == htfd_pkg::POS_HUM_CRC) ? htfd_pkg::POS_TEMP_MSB : eff_pos + 3'd1;
  end

  // The humidity CRC byte closes the frame and yields the result.
  assign has_result                  = (eff_pos == htfd_pkg::POS_HUM_CRC);
  assign result.temperature_centideg = held_temp_r;
  assign result.humidity_percent     = held_hum_nxt;
  assign result.temp_crc_ok          = temp_ok_r;
  assign result.hum_crc_ok           = crc_match;

  // Control and held values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= htfd_pkg::POS_TEMP_MSB;
      crc_r       <= htfd_pkg::CRC_INIT;
      held_temp_r <= '0;
      held_hum_r  <= '0;
      temp_ok_r   <= 1'b0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      held_temp_r <= held_temp_nxt;
      held_hum_r  <= held_hum_nxt;
      temp_ok_r   <= temp_ok_nxt;
    end
  end

  // The word buffer is always written before it is read.
  always_ff @(posedge clk) begin
    if (step) begin
      word_r <= word_nxt;
    end
  end

endmodule

@@ rtl/humidity_temp_frame_decoder_core.sv @@
// Humidity/temperature frame decoder.
// The input channel takes one received sensor byte per request: in_tdata
// carries the byte, in_tuser marks the first byte of a six-byte frame
// (temperature MSB, LSB, CRC, humidity MSB, LSB, CRC). Each word is checked
// with CRC-8 (poly 0x31, init 0xFF); a good word updates its held value,
// a bad one leaves it.
// After the sixth byte one request leaves on the output channel with both
// held values and both CRC flags; the other five bytes give no output.
// The input register takes a byte at acceptance; a closing byte's result
// then moves into the output register, which drives out_tvalid, and stays
// there until the receiver takes it with out_tready.
// Throughput: one byte per cycle unless a closing byte waits for the output;
// the CRC step and the constant multiplies sit in the single logic stage
// between the input and output registers. Reset clears the frame position,
// the CRC, the held values and both channels. When the receiver stalls, the
// output register holds its result and the input stage keeps taking bytes
// until a second result is waiting, at which point in_tready drops.
module humidity_temp_frame_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [14:0] temperature_centideg, [21:15] humidity_percent,
                                  // [22] temp_crc_ok, [23] hum_crc_ok
);

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_start_r;
  logic              has_result;
  logic              out_free;
  logic              s1_fire;
  logic              out_valid_r;
  htfd_pkg::result_t result;
  htfd_pkg::result_t out_data_r;

  // Stage handshake: bytes without a result never wait for the output.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!has_result || out_free);
  assign in_tready = !s1_valid_r || s1_fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  htfd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_fire),
    .rx_byte     (s1_byte_r),
    .frame_start (s1_start_r),
    .has_result  (has_result),
    .result      (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.hum_crc_ok, out_data_r.temp_crc_ok,
                       out_data_r.humidity_percent, out_data_r.temperature_centideg};

  // The input side is open right after reset.
  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("in_tready low after reset");

  // A closing byte that moves on always lands in the output register.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && has_result) |=> out_valid_r)
    else $error("result lost on its way to the output register");

  // A closing byte blocked by a full output stays in the input stage.
  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && has_result && !out_free) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("closing byte dropped while output was stalled");

endmodule
